@@ design/box_filter_3x3_reflect_border_defines.svh @@
// Assertion macros shared by the box filter checker.
// Needs clk and rst in the scope where a macro is used.
`ifndef BOX_FILTER_3X3_REFLECT_BORDER_DEFINES_SVH
`define BOX_FILTER_3X3_REFLECT_BORDER_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define BOX3_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a condition in the cycle after its trigger
`define BOX3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/box3_pkg.sv @@
// Types, constants and column sum helpers for the 3x3 box filter.
// No dependencies; used by the filter top level and its checker.
package box3_pkg;

  localparam int PIXEL_WIDTH    = 8;
  localparam int CFG_DATA_WIDTH = 11;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int COL_SUM_WIDTH  = 10;
  localparam int SUM_WIDTH      = 12;

  // Reset frame size
  localparam int RESET_FRAME_WIDTH  = 640;
  localparam int RESET_FRAME_HEIGHT = 480;

  // Divide by nine: (x * 7282) >> 16 is exact for x below 2300
  localparam int RECIP_WIDTH  = 13;
  localparam logic [RECIP_WIDTH-1:0] RECIP_NINE = 13'd7282;
  localparam int RECIP_SHIFT  = 16;
  localparam int PROD_WIDTH   = SUM_WIDTH + RECIP_WIDTH;
  localparam logic [SUM_WIDTH-1:0] ROUND_BIAS = 12'd4;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // One window column: three vertically adjacent pixels
  typedef struct packed {
    logic [PIXEL_WIDTH-1:0] bottom;
    logic [PIXEL_WIDTH-1:0] middle;
    logic [PIXEL_WIDTH-1:0] top;
  } column_t;

  // Full column sum
  function automatic logic [COL_SUM_WIDTH-1:0] top_sum(input column_t col);
    top_sum = COL_SUM_WIDTH'(col.top) + COL_SUM_WIDTH'(col.middle)
            + COL_SUM_WIDTH'(col.bottom);
  endfunction

  // Column sum with the bottom edge mirrored (bottom counts twice)
  function automatic logic [COL_SUM_WIDTH-1:0] bot_sum(input column_t col);
    bot_sum = COL_SUM_WIDTH'(col.middle) + {1'b0, col.bottom, 1'b0};
  endfunction

endpackage

@@ design/box_filter_3x3_reflect_border.sv @@
// 3x3 box (mean) filter over a raster stream of 8-bit grey pixels, with the
// frame border mirrored so the edge row or column counts twice. Each result
// is the rounded mean (sum + 4) / 9. Results lag one row and one column; the
// last pixel of a row releases one more result and every pixel of the last
// row after the first releases the results of the last row too, so a pixel
// gives 0 to 4 words; on the last row the last two rows interleave by column.
// A pixel with at most one word is taken every cycle while the output is not
// stalled; one with more holds the input until all have loaded, as the output
// register hands on one word per cycle when free. A pixel's first result
// passes from the working stage, where the line stores are read as it is
// taken, to the output register. The line stores need no clearing after
// reset. Writing frame_width or frame_height restarts the frame; sizes are
// clamped to 2..MAX_WIDTH and 2..MAX_HEIGHT.
// Depends on box3_pkg.
module box_filter_3x3_reflect_border #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [box3_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [box3_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [box3_pkg::PIXEL_WIDTH-1:0]       pixel,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [box3_pkg::PIXEL_WIDTH-1:0]       mean_value,
  output logic                                   last_in_run,
  output logic                                   frame_end
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int RESET_W = (box3_pkg::RESET_FRAME_WIDTH > MAX_WIDTH) ?
                           MAX_WIDTH : box3_pkg::RESET_FRAME_WIDTH;
  localparam int RESET_H = (box3_pkg::RESET_FRAME_HEIGHT > MAX_HEIGHT) ?
                           MAX_HEIGHT : box3_pkg::RESET_FRAME_HEIGHT;

  // Configuration, held as last column and last row index
  logic [CW-1:0] last_col;
  logic [RW-1:0] last_row;
  logic [CW-1:0] last_col_next;
  logic [RW-1:0] last_row_next;

  // Position of the next pixel
  logic [CW-1:0] col;
  logic [RW-1:0] row;

  // Working stage
  logic                              s_valid;
  logic [3:0]                        s_pending;
  logic [CW-1:0]                     s_col;
  logic                              s_row_one;
  logic                              s_col_one;
  logic [box3_pkg::PIXEL_WIDTH-1:0]  s_pixel;
  logic [box3_pkg::PIXEL_WIDTH-1:0]  rd_upper;
  logic [box3_pkg::PIXEL_WIDTH-1:0]  rd_middle;

  // Line stores
  logic [box3_pkg::PIXEL_WIDTH-1:0] line_upper  [MAX_WIDTH];
  logic [box3_pkg::PIXEL_WIDTH-1:0] line_middle [MAX_WIDTH];

  // Window of the two previous columns
  box3_pkg::column_t prev1;
  box3_pkg::column_t prev2;

  logic              accept;
  logic              load;
  logic              retire;
  logic              out_free;
  logic [3:0]        pick;
  logic [1:0]        pick_idx;
  logic [3:0]        remain;
  logic [3:0]        run_mask;
  box3_pkg::column_t cur_col;
  box3_pkg::column_t left_col;
  logic [box3_pkg::SUM_WIDTH-1:0]  sum_sel;
  logic [box3_pkg::PROD_WIDTH-1:0] product;
  logic [31:0]       cfg_value;

  // Clamp a written size to the supported range, as a last index
  always_comb begin
    cfg_value     = 32'(cfg_data);
    last_col_next = last_col;
    last_row_next = last_row;
    if (cfg_value < 32'd2) begin
      last_col_next = CW'(1);
      last_row_next = RW'(1);
    end else begin
      last_col_next = (cfg_value > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1) :
                      CW'(cfg_value - 32'd1);
      last_row_next = (cfg_value > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT - 1) :
                      RW'(cfg_value - 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= CW'(RESET_W - 1);
      last_row <= RW'(RESET_H - 1);
    end else if (cfg_write) begin
      case (cfg_index)
        box3_pkg::REG_FRAME_WIDTH:  last_col <= last_col_next;
        box3_pkg::REG_FRAME_HEIGHT: last_row <= last_row_next;
        default: ;
      endcase
    end
  end

  // Handshake: output register frees as its word is taken
  assign out_free = !out_valid || out_ready;
  assign load     = s_valid && (s_pending != 4'd0) && out_free;
  assign remain   = s_pending & ~pick;
  assign retire   = s_valid && ((s_pending == 4'd0) || (load && (remain == 4'd0)));
  assign in_ready = !s_valid || retire;
  assign accept   = in_valid && in_ready;

  // Pick the earliest pending result
  always_comb begin
    pick     = 4'd0;
    pick_idx = 2'd0;
    if (s_pending[0]) begin
      pick = 4'b0001; pick_idx = 2'd0;
    end else if (s_pending[1]) begin
      pick = 4'b0010; pick_idx = 2'd1;
    end else if (s_pending[2]) begin
      pick = 4'b0100; pick_idx = 2'd2;
    end else if (s_pending[3]) begin
      pick = 4'b1000; pick_idx = 2'd3;
    end
  end

  // Results this pixel releases, from its position
  always_comb begin
    run_mask = 4'd0;
    if (row != RW'(0)) begin
      run_mask[0] = (col != CW'(0));
      run_mask[1] = (col == last_col);
      run_mask[2] = (row == last_row) && (col != CW'(0));
      run_mask[3] = (row == last_row) && (col == last_col);
    end
  end

  // Advance position and load the working stage
  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      s_valid   <= 1'b0;
      s_pending <= 4'd0;
    end else if (cfg_write) begin
      col <= '0;
      row <= '0;
    end else begin
      if (accept) begin
        s_valid   <= 1'b1;
        s_pending <= run_mask;
        if (col == last_col) begin
          col <= '0;
          row <= (row == last_row) ? RW'(0) : row + RW'(1);
        end else begin
          col <= col + CW'(1);
        end
      end else if (retire) begin
        s_valid   <= 1'b0;
        s_pending <= 4'd0;
      end else if (load) begin
        s_pending <= remain;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s_col     <= col;
      s_row_one <= (row == RW'(1));
      s_col_one <= (col == CW'(1));
      s_pixel   <= pixel;
    end
  end

  // Line stores: read as the pixel is taken, write back as it leaves
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_upper  <= line_upper[col];
      rd_middle <= line_middle[col];
    end
    if (retire) begin
      line_upper[s_col]  <= rd_middle;
      line_middle[s_col] <= s_pixel;
    end
  end

  // Current column, mirroring the top edge on the second row
  always_comb begin
    cur_col.top    = s_row_one ? rd_middle : rd_upper;
    cur_col.middle = rd_middle;
    cur_col.bottom = s_pixel;
    left_col       = s_col_one ? prev1 : prev2;
  end

  // Shift the window as the pixel leaves
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      prev1 <= '0;
      prev2 <= '0;
    end else if (retire) begin
      prev2 <= prev1;
      prev1 <= cur_col;
    end
  end

  // Sum of the picked result
  always_comb begin
    case (pick_idx)
      2'd0: sum_sel = box3_pkg::SUM_WIDTH'(box3_pkg::top_sum(left_col))
                    + box3_pkg::SUM_WIDTH'(box3_pkg::top_sum(prev1))
                    + box3_pkg::SUM_WIDTH'(box3_pkg::top_sum(cur_col));
      2'd1: sum_sel = box3_pkg::SUM_WIDTH'(box3_pkg::top_sum(prev1))
                    + {1'b0, box3_pkg::top_sum(cur_col), 1'b0};
      2'd2: sum_sel = box3_pkg::SUM_WIDTH'(box3_pkg::bot_sum(left_col))
                    + box3_pkg::SUM_WIDTH'(box3_pkg::bot_sum(prev1))
                    + box3_pkg::SUM_WIDTH'(box3_pkg::bot_sum(cur_col));
      default: sum_sel = box3_pkg::SUM_WIDTH'(box3_pkg::bot_sum(prev1))
                       + {1'b0, box3_pkg::bot_sum(cur_col), 1'b0};
    endcase
  end

  // Round and divide by nine through the reciprocal
  assign product = box3_pkg::PROD_WIDTH'(sum_sel + box3_pkg::ROUND_BIAS)
                 * box3_pkg::PROD_WIDTH'(box3_pkg::RECIP_NINE);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mean_value  <= product[box3_pkg::RECIP_SHIFT +: box3_pkg::PIXEL_WIDTH];
      last_in_run <= (remain == 4'd0);
      frame_end   <= pick[3];
    end
  end

endmodule

@@ design/box3_checker.sv @@
// Port-level checks for the 3x3 box filter, bound to its top level.
// Depends on box3_pkg and box_filter_3x3_reflect_border_defines.svh.
`include "box_filter_3x3_reflect_border_defines.svh"

module box3_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [box3_pkg::PIXEL_WIDTH-1:0]  pixel,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [box3_pkg::PIXEL_WIDTH-1:0]  mean_value,
  input logic                              last_in_run,
  input logic                              frame_end
);

  logic                             in_stall;
  logic                             out_stall;
  logic                             out_take;
  logic                             end_word;
  logic [box3_pkg::PIXEL_WIDTH+1:0] out_word;

  assign in_stall  = in_valid && !in_ready;
  assign out_stall = out_valid && !out_ready;
  assign out_take  = out_valid && out_ready;
  assign end_word  = out_valid && frame_end;
  assign out_word  = {mean_value, last_in_run, frame_end};

  // Hold a waiting input word
  `BOX3_ASSERT_NEXT(a_in_hold, in_stall, in_valid && $stable(pixel), "input word dropped")

  // Hold a stalled word
  `BOX3_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "output word changed")

  // Close the run on the frame's last word
  `BOX3_ASSERT_NOW(a_frame_end_last, end_word, last_in_run, "frame end word not last in run")

  // Never mark two frame ends in a row
  `BOX3_ASSERT_NEXT(a_frame_end_once, out_take && frame_end, !end_word, "frame end twice")

endmodule

bind box_filter_3x3_reflect_border box3_checker u_box3_checker (.*);

@@ sim/tb.sv @@
// Self-checking bench for box_filter_3x3_reflect_border: a directed table and random frames.
// It predicts each mean word and checks the words in order. Needs box3_pkg and the filter RTL.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned MAX_DIM       = 1024;
  localparam int          DIM_BITS      = $clog2(MAX_DIM);
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned PHASE_QUOTA   = 45;

  // One result word as it leaves the filter
  typedef struct packed {
    logic [box3_pkg::PIXEL_WIDTH-1:0] mean;
    logic                             last;
    logic                             fend;
  } mean_word_t;

  // One row of the directed table
  typedef enum logic {STEP_WRITE, STEP_PIXEL} step_kind_t;

  typedef struct packed {
    step_kind_t                          kind;
    box3_pkg::cfg_reg_t                  sel;
    logic [box3_pkg::CFG_DATA_WIDTH-1:0] value;
    logic [box3_pkg::PIXEL_WIDTH-1:0]    pix;
    logic                                typed;
    logic [box3_pkg::PIXEL_WIDTH-1:0]    mean;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 33;

  logic                                 clk;
  logic                                 rst = 1'b1;
  logic                                 cfg_write;
  logic [box3_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [box3_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;
  logic                                 in_valid;
  logic                                 in_ready;
  logic [box3_pkg::PIXEL_WIDTH-1:0]     pixel;
  logic                                 out_valid;
  logic                                 out_ready;
  logic [box3_pkg::PIXEL_WIDTH-1:0]     mean_value;
  logic                                 last_in_run;
  logic                                 frame_end;

  // Idling mix, changed between phases
  int unsigned sender_gap_pct     = 8;
  int unsigned receiver_stall_pct = 82;
  int unsigned mismatches         = 0;

  // Mean words still to come, oldest first
  mean_word_t awaited_means [$];

  // Filter state as seen by the bench
  logic [box3_pkg::CFG_DATA_WIDTH-1:0] frame_w =
    box3_pkg::CFG_DATA_WIDTH'(box3_pkg::RESET_FRAME_WIDTH);
  logic [box3_pkg::CFG_DATA_WIDTH-1:0] frame_h =
    box3_pkg::CFG_DATA_WIDTH'(box3_pkg::RESET_FRAME_HEIGHT);
  logic [box3_pkg::PIXEL_WIDTH-1:0]    row_above [MAX_DIM];
  logic [box3_pkg::PIXEL_WIDTH-1:0]    row_mid   [MAX_DIM];
  box3_pkg::column_t                   win_near = '0;
  box3_pkg::column_t                   win_far  = '0;
  int unsigned                         row_pos  = 0;
  int unsigned                         col_pos  = 0;

  // Extremes, then small clamped sizes, walks of single bits, then large clamped sizes
  stim_row_t directed_steps [DIRECTED_ROWS] = '{
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'h00, 1'b0, 8'd0},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'hFF, 1'b0, 8'd0},
    '{STEP_WRITE, box3_pkg::REG_FRAME_WIDTH,  11'd2,    8'h00, 1'b0, 8'd0},
    '{STEP_WRITE, box3_pkg::REG_FRAME_HEIGHT, 11'd2,    8'h00, 1'b0, 8'd0},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'hFF, 1'b1, 8'd255},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'hFF, 1'b1, 8'd255},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'hFF, 1'b1, 8'd255},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'hFF, 1'b1, 8'd255},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'h00, 1'b1, 8'd0},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'h00, 1'b1, 8'd0},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'h00, 1'b1, 8'd0},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'h00, 1'b1, 8'd0},
    '{STEP_WRITE, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'h00, 1'b0, 8'd0},
    '{STEP_WRITE, box3_pkg::REG_FRAME_HEIGHT, 11'd1,    8'h00, 1'b0, 8'd0},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'h55, 1'b0, 8'd0},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'hAA, 1'b0, 8'd0},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'hFF, 1'b0, 8'd0},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'h00, 1'b0, 8'd0},
    '{STEP_WRITE, box3_pkg::REG_FRAME_WIDTH,  11'd3,    8'h00, 1'b0, 8'd0},
    '{STEP_WRITE, box3_pkg::REG_FRAME_HEIGHT, 11'd3,    8'h00, 1'b0, 8'd0},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'h01, 1'b0, 8'd0},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'h02, 1'b0, 8'd0},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'h04, 1'b0, 8'd0},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'h08, 1'b0, 8'd0},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'h10, 1'b0, 8'd0},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'h20, 1'b0, 8'd0},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'h40, 1'b0, 8'd0},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'h80, 1'b0, 8'd0},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'hFF, 1'b0, 8'd0},
    '{STEP_WRITE, box3_pkg::REG_FRAME_WIDTH,  11'd2047, 8'h00, 1'b0, 8'd0},
    '{STEP_WRITE, box3_pkg::REG_FRAME_HEIGHT, 11'd2047, 8'h00, 1'b0, 8'd0},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'h80, 1'b0, 8'd0},
    '{STEP_PIXEL, box3_pkg::REG_FRAME_WIDTH,  11'd0,    8'h7F, 1'b0, 8'd0}
  };

  box_filter_3x3_reflect_border #(
    .MAX_WIDTH  (MAX_DIM),
    .MAX_HEIGHT (MAX_DIM)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel       (pixel),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mean_value  (mean_value),
    .last_in_run (last_in_run),
    .frame_end   (frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sizes outside 2..MAX_DIM are pulled to the nearest bound
  function automatic int unsigned clamp_dim(input logic [box3_pkg::CFG_DATA_WIDTH-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  function automatic int unsigned column_total(input box3_pkg::column_t col);
    return 32'(col.top) + 32'(col.middle) + 32'(col.bottom);
  endfunction

  // Last row: the bottom pixel stands in for the row below
  function automatic int unsigned edge_total(input box3_pkg::column_t col);
    return 32'(col.middle) + 2 * 32'(col.bottom);
  endfunction

  function automatic mean_word_t rounded_mean(input int unsigned sum, input logic at_end);
    mean_word_t word;
    word.mean = box3_pkg::PIXEL_WIDTH'((sum + 4) / 9);
    word.last = 1'b0;
    word.fend = at_end;
    return word;
  endfunction

  function automatic void note_mismatch(input string field, input int unsigned want,
                                        input int unsigned got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    mismatches++;
  endfunction

  // Advance the window by one pixel and queue the mean words it releases
  task automatic filter_pixel(input logic [box3_pkg::PIXEL_WIDTH-1:0] value,
                              input logic typed,
                              input logic [box3_pkg::PIXEL_WIDTH-1:0] typed_mean);
    int unsigned         w, h, c, r;
    logic [DIM_BITS-1:0] ci;
    box3_pkg::column_t   cur, left;
    mean_word_t          run [$];
    w  = clamp_dim(frame_w);
    h  = clamp_dim(frame_h);
    c  = (col_pos > w - 1) ? w - 1 : col_pos;
    r  = (row_pos > h - 1) ? h - 1 : row_pos;
    ci = DIM_BITS'(c);
    // On the second row the top edge is mirrored from the first
    cur.top    = (r == 1) ? row_mid[ci] : row_above[ci];
    cur.middle = row_mid[ci];
    cur.bottom = value;
    left = (c == 1) ? win_near : win_far;
    if (r >= 1) begin
      if (c >= 1)
        run.push_back(rounded_mean(column_total(left) + column_total(win_near)
                                   + column_total(cur), 1'b0));
      if (c == w - 1)
        run.push_back(rounded_mean(column_total(win_near) + 2 * column_total(cur), 1'b0));
      if (r == h - 1) begin
        if (c >= 1)
          run.push_back(rounded_mean(edge_total(left) + edge_total(win_near)
                                     + edge_total(cur), 1'b0));
        if (c == w - 1)
          run.push_back(rounded_mean(edge_total(win_near) + 2 * edge_total(cur), 1'b1));
      end
    end
    if (run.size() != 0)
      run[run.size() - 1].last = 1'b1;
    foreach (run[i]) begin
      if (typed)
        run[i].mean = typed_mean;
      awaited_means.push_back(run[i]);
    end
    // Shift the line stores and the window, then step the raster position
    row_above[ci] = row_mid[ci];
    row_mid[ci]   = value;
    win_far       = win_near;
    win_near      = cur;
    if (c >= w - 1) begin
      col_pos = 0;
      row_pos = (r >= h - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  // Offer one pixel word and hold it until taken
  task automatic send_pixel(input logic [box3_pkg::PIXEL_WIDTH-1:0] value,
                            input logic typed,
                            input logic [box3_pkg::PIXEL_WIDTH-1:0] typed_mean);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= value;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    filter_pixel(value, typed, typed_mean);
  endtask

  // Drop valid, wait for every awaited word, then let the pipeline settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_means.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write a size register once the filter is idle; this restarts the frame
  task automatic write_reg(input box3_pkg::cfg_reg_t sel,
                           input logic [box3_pkg::CFG_DATA_WIDTH-1:0] value);
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (sel == box3_pkg::REG_FRAME_WIDTH)
      frame_w = value;
    else
      frame_h = value;
    win_near = '0;
    win_far  = '0;
    row_pos  = 0;
    col_pos  = 0;
  endtask

  // Small random frames, mostly whole, now and then cut short by the next write
  task automatic run_random_frames(input int unsigned quota);
    int unsigned                         sent, area, count;
    logic [box3_pkg::CFG_DATA_WIDTH-1:0] w_val, h_val;
    sent = 0;
    while (sent < quota) begin
      w_val = ($urandom_range(0, 7) == 0) ? box3_pkg::CFG_DATA_WIDTH'($urandom_range(0, 1))
                                          : box3_pkg::CFG_DATA_WIDTH'($urandom_range(2, 7));
      h_val = ($urandom_range(0, 7) == 0) ? box3_pkg::CFG_DATA_WIDTH'($urandom_range(0, 1))
                                          : box3_pkg::CFG_DATA_WIDTH'($urandom_range(2, 5));
      if ($urandom_range(0, 1) == 0) begin
        write_reg(box3_pkg::REG_FRAME_WIDTH, w_val);
        write_reg(box3_pkg::REG_FRAME_HEIGHT, h_val);
      end else begin
        write_reg(box3_pkg::REG_FRAME_HEIGHT, h_val);
        write_reg(box3_pkg::REG_FRAME_WIDTH, w_val);
      end
      area  = clamp_dim(frame_w) * clamp_dim(frame_h);
      count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, area - 1)
                                          : area * $urandom_range(1, 2);
      // Keep the phase to its share of pixels
      if (count > quota - sent)
        count = quota - sent;
      repeat (count)
        send_pixel(($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(0, 255)),
                   1'b0, 8'd0);
      sent += count;
    end
  endtask

  // Take mean words and compare each with the oldest awaited one
  initial begin : result_check
    mean_word_t head;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (awaited_means.size() == 0) begin
          $display("%0t: unexpected word, expected none, got mean %0d last %0b end %0b",
                   $time, mean_value, last_in_run, frame_end);
          mismatches++;
        end else begin
          head = awaited_means.pop_front();
          if (mean_value !== head.mean)
            note_mismatch("mean_value", head.mean, mean_value);
          if (last_in_run !== head.last)
            note_mismatch("last_in_run", head.last, last_in_run);
          if (frame_end !== head.fend)
            note_mismatch("frame_end", head.fend, frame_end);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // End the run if nothing moves on either side for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("box_filter_3x3_reflect_border test failed");
    $finish;
  end

  initial begin : stimulus
    cfg_write = 1'b0;
    cfg_index = box3_pkg::REG_FRAME_WIDTH;
    cfg_data  = '0;
    in_valid  = 1'b0;
    pixel     = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Sender nearly always ready, receiver mostly stalled
    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_WRITE)
        write_reg(directed_steps[i].sel, directed_steps[i].value);
      else
        send_pixel(directed_steps[i].pix, directed_steps[i].typed, directed_steps[i].mean);
    end
    run_random_frames(PHASE_QUOTA);

    // Sender mostly idle, receiver nearly always ready
    sender_gap_pct     = 82;
    receiver_stall_pct = 8;
    run_random_frames(PHASE_QUOTA);

    // Full rate both ways
    sender_gap_pct     = 0;
    receiver_stall_pct = 0;
    run_random_frames(PHASE_QUOTA);

    drain_results();
    if (mismatches == 0 && awaited_means.size() == 0)
      $display("box_filter_3x3_reflect_border test passed");
    else
      $display("box_filter_3x3_reflect_border test failed");
    $finish;
  end

endmodule
